// ----- hdl/chl_pkg.sv -----
// ----------------------------------------------------------------------------
// chl_pkg
// shared sizes, operation codes and status codes for the compacting handle list
// ----------------------------------------------------------------------------
package chl_pkg;

    localparam int CAPACITY    = 128;
    localparam int HANDLE_BITS = 16;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    localparam int OP_W       = 3;
    localparam int POS_W      = 16;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int ECOUNT_W   = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND        = 3'd0,
        OP_REMOVE_AT     = 3'd1,
        OP_REMOVE_HANDLE = 3'd2,
        OP_READ          = 3'd3,
        OP_CLEAR         = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

endpackage

// ----- hdl/chl_ram.sv -----
// ----------------------------------------------------------------------------
// chl_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module chl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/compacting_handle_list.sv -----
// ----------------------------------------------------------------------------
// compacting_handle_list
// fixed-capacity ordered handle list with append, remove, search, read, clear
// ----------------------------------------------------------------------------
// channel  dir  fields (tdata, lowest bit first)
// s_axis   in   operation[2:0] position[18:3] handle[34:19], zero pad to 40
// m_axis   out  status[1:0] read_handle[17:2] entry_count[25:18], zero pad to 32
//
// append, clear, bad index and empty read reply at once; read first passes a ram read state
// remove at index p shifts the entries above p down, one entry moved per cycle
// remove by handle searches from index 0 for the first match, then shifts as above;
// both go through the single write port and the registered read port of the entry ram
// synchronous active-low reset empties the list; s_axis stalls while busy
// and while a finished item waits on a stalled m_axis
// ----------------------------------------------------------------------------
module compacting_handle_list
    import chl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // operation, position, handle
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // status, read_handle, entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_READ,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [COUNT_W-1:0]    r_ra, n_ra;
    logic [ADDR_W-1:0]     r_wa, n_wa;
    logic                  r_pv, n_pv;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    t_status               r_res_status, n_res_status;
    logic [HANDLE_W-1:0]   r_res_handle, n_res_handle;
    logic                  r_ov, n_ov;
    t_status               r_o_status, n_o_status;
    logic [HANDLE_W-1:0]   r_o_handle, n_o_handle;
    logic [ECOUNT_W-1:0]   r_o_count, n_o_count;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [HANDLE_BITS-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [HANDLE_BITS-1:0] ram_rdata;

    logic                  in_fire;
    logic [OP_W-1:0]       in_op;
    logic [POS_W-1:0]      in_pos;
    logic [HANDLE_W-1:0]   in_handle;
    logic [POS_W-1:0]      count_ext;
    logic                  pos_neg;
    logic                  pos_below;
    logic                  ra_below;

    assign in_op     = s_axis_tdata[2:0];
    assign in_pos    = s_axis_tdata[18:3];
    assign in_handle = s_axis_tdata[34:19];
    assign count_ext = POS_W'(r_count);
    assign pos_neg   = in_pos[POS_W-1];
    assign pos_below = !pos_neg && (in_pos < count_ext);
    assign ra_below  = (r_ra < r_count);

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    chl_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ra         = r_ra;
        n_wa         = r_wa;
        n_pv         = r_pv;
        n_handle     = r_handle;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_ov         = r_ov;
        n_o_status   = r_o_status;
        n_o_handle   = r_o_handle;
        n_o_count    = r_o_count;
        ram_we       = 1'b0;
        ram_waddr    = r_wa;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = r_ra[ADDR_W-1:0];

        if (m_axis_tvalid && m_axis_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res_status = ST_DONE;
                    n_res_handle = '0;
                    n_handle     = HANDLE_BITS'(in_handle);
                    n_pv         = 1'b0;
                    n_state      = S_DONE;
                    case (t_op'(in_op))
                        OP_APPEND: begin
                            if (r_count < COUNT_W'(CAPACITY)) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[ADDR_W-1:0];
                                ram_wdata = HANDLE_BITS'(in_handle);
                                n_count   = r_count + 1'b1;
                            end else begin
                                n_res_status = ST_FULL;
                            end
                        end
                        OP_REMOVE_AT: begin
                            if (pos_below) begin
                                n_ra    = COUNT_W'(in_pos) + 1'b1;
                                n_wa    = in_pos[ADDR_W-1:0];
                                n_state = S_SHIFT;
                            end else begin
                                n_res_status = ST_MISS;
                            end
                        end
                        OP_REMOVE_HANDLE: begin
                            n_ra    = '0;
                            n_wa    = '0;
                            n_state = S_SEARCH;
                        end
                        OP_READ: begin
                            if (r_count != '0) begin
                                ram_re = 1'b1;
                                if (pos_neg) begin
                                    ram_raddr = '0;
                                end else if (pos_below) begin
                                    ram_raddr = in_pos[ADDR_W-1:0];
                                end else begin
                                    ram_raddr = ADDR_W'(r_count - 1'b1);
                                end
                                n_state = S_READ;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_handle = HANDLE_W'(ram_rdata);
                n_state      = S_DONE;
            end
            S_SEARCH: begin
                if (ra_below) begin
                    ram_re = 1'b1;
                    n_ra   = r_ra + 1'b1;
                end
                n_pv = ra_below;
                if (r_pv) begin
                    if (ram_rdata == r_handle) begin
                        n_ra    = COUNT_W'(r_wa) + 1'b1;
                        n_pv    = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_wa = r_wa + 1'b1;
                    end
                end else if (!ra_below) begin
                    n_res_status = ST_MISS;
                    n_state      = S_DONE;
                end
            end
            S_SHIFT: begin
                if (ra_below) begin
                    ram_re = 1'b1;
                    n_ra   = r_ra + 1'b1;
                end
                n_pv = ra_below;
                if (r_pv) begin
                    ram_we = 1'b1;
                    n_wa   = r_wa + 1'b1;
                end else if (!ra_below) begin
                    n_count      = r_count - 1'b1;
                    n_res_status = ST_DONE;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_res_status;
                    n_o_handle = r_res_handle;
                    n_o_count  = ECOUNT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_ov    <= n_ov;
        end
        r_ra         <= n_ra;
        r_wa         <= n_wa;
        r_handle     <= n_handle;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_o_status   <= n_o_status;
        r_o_handle   <= n_o_handle;
        r_o_count    <= n_o_count;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_o_count, r_o_handle, r_o_status};

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_list : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (COUNT_W'(ram_waddr) <= r_count))
        else $error("entry write beyond end of list");

    a_shift_write_pending : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && ram_we) |-> r_pv)
        else $error("shift write without read data");

    a_item_leaves_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// streams list operations into compacting_handle_list and checks each reply
// against a behavioural model of the list held in the bench; directed corner
// cases first, then random phases that grow, shrink and fill the list, with
// random idling on both streams, a long output stall and a full drain
// ----------------------------------------------------------------------------
module testbench;
    import chl_pkg::*;

    localparam int CMD_TARGET   = 725;
    localparam int CALM_ITEMS   = 80;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_GRACE  = 300;
    localparam int POOL_SIZE    = 24;
    localparam int OP_CODE_MAX  = (1 << OP_W) - 1;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [POS_W-1:0]    pos;
        logic [HANDLE_W-1:0] handle;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] read_handle;
        logic [ECOUNT_W-1:0] entry_count;
    } t_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // operation, position, handle
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // status, read_handle, entry_count

    // list model
    logic [HANDLE_W-1:0] stored [CAPACITY];
    int                  held = 0;

    t_cmd   pending_cmds [$];
    t_reply due_replies [$];
    logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

    logic cmd_taken = 1'b0;
    logic calm = 1'b0;
    int   idle_pct = 0;
    int   tx_gap_left = 0;
    int   rx_gap_left = 0;
    int   rx_hold_left = 0;
    int   hold_requests = 0;
    int   holds_served = 0;
    int   cmds_queued = 0;
    int   quiet_cycles = 0;
    int   mismatches = 0;
    int   items_checked = 0;
    int   full_refusals = 0;
    int   misses = 0;
    int   reads_done = 0;
    int   peak_len = 0;

    compacting_handle_list i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_reply list_apply(t_cmd c);
        t_reply r;
        int     p;
        int     victim;
        int     at;
        r = '0;
        r.status = ST_DONE;
        p = $signed(c.pos);
        victim = -1;
        case (c.op)
            OP_APPEND: begin
                if (held < CAPACITY) begin
                    stored[held] = c.handle;
                    held++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_REMOVE_AT: begin
                if (p < 0 || p >= held) r.status = ST_MISS;
                else victim = p;
            end
            OP_REMOVE_HANDLE: begin
                for (int i = 0; i < held; i++)
                    if (victim < 0 && stored[i] == c.handle) victim = i;
                if (victim < 0) r.status = ST_MISS;
            end
            OP_READ: begin
                if (held > 0) begin
                    at = (p < 0) ? 0 : (p >= held) ? held - 1 : p;
                    r.read_handle = stored[at];
                end
            end
            OP_CLEAR: held = 0;
            default: ;
        endcase
        if (victim >= 0) begin
            for (int i = victim; i < held - 1; i++) stored[i] = stored[i + 1];
            held--;
        end
        r.entry_count = held[ECOUNT_W-1:0];
        return r;
    endfunction

    // driver
    always @(negedge i_clk) begin : drive_proc
        t_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !cmd_taken) begin
        end else if (tx_gap_left > 0) begin
            tx_gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            tx_gap_left = $urandom_range(1, 11) - 1;
            s_axis_tvalid <= 1'b0;
        end else begin
            nxt = pending_cmds.pop_front();
            s_axis_tdata  <= {{(IN_DATA_W-OP_W-POS_W-HANDLE_W){1'b0}}, nxt.handle, nxt.pos, nxt.op};
            s_axis_tvalid <= 1'b1;
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (holds_served < hold_requests) begin
            holds_served++;
            rx_hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            rx_gap_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin : watch_proc
        t_reply got;
        t_reply want;
        t_cmd   seen;
        cmd_taken = 1'b0;
        quiet_cycles++;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            quiet_cycles = 0;
            got.status      = m_axis_tdata[1:0];
            got.read_handle = m_axis_tdata[17:2];
            got.entry_count = m_axis_tdata[25:18];
            if (due_replies.size() == 0) begin
                $error("result arrived with nothing outstanding");
                mismatches++;
            end else begin
                want = due_replies.pop_front();
                items_checked++;
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.read_handle !== want.read_handle) begin
                    $error("read_handle: expected %0h, got %0h",
                           want.read_handle, got.read_handle);
                    mismatches++;
                end
                if (got.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, got.entry_count);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            quiet_cycles = 0;
            cmd_taken = 1'b1;
            seen.op     = s_axis_tdata[2:0];
            seen.pos    = s_axis_tdata[18:3];
            seen.handle = s_axis_tdata[34:19];
            want = list_apply(seen);
            due_replies.push_back(want);
            if (want.status == ST_FULL) full_refusals++;
            if (want.status == ST_MISS) misses++;
            if (seen.op == OP_READ) reads_done++;
            if (held > peak_len) peak_len = held;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("compacting_handle_list: mismatch");
            $finish;
        end
    end

    task automatic await_room();
        while (pending_cmds.size() >= 2) @(negedge i_clk);
    endtask

    task automatic offer_cmd(input logic [OP_W-1:0] op, input int pos,
                             input logic [HANDLE_W-1:0] h);
        t_cmd c;
        await_room();
        c.op     = op;
        c.pos    = pos[POS_W-1:0];
        c.handle = h;
        pending_cmds.push_back(c);
        cmds_queued++;
        if (cmds_queued >= CMD_TARGET - CALM_ITEMS) calm = 1'b1;
    endtask

    task automatic await_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || due_replies.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 9) < 7) return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        return HANDLE_W'($urandom);
    endfunction

    function automatic int pick_position();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) return $urandom_range(0, held);
        if (roll < 8) return $urandom_range(0, 3);
        if (roll == 8) return -int'($urandom_range(1, 4));
        return $signed(POS_W'($urandom));
    endfunction

    task automatic offer_random_cmd(input int grow_pct);
        int                  roll;
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] h;
        int                  pos;
        await_room();
        pos = pick_position();
        h   = pick_handle();
        if ($urandom_range(0, 99) < grow_pct) begin
            op = OP_APPEND;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                op = OP_REMOVE_AT;
            end else if (roll < 60) begin
                op = OP_REMOVE_HANDLE;
                if (held > 0 && $urandom_range(0, 3) != 0)
                    h = stored[$urandom_range(0, held - 1)];
            end else if (roll < 94) begin
                op = OP_READ;
            end else if (roll < 97) begin
                op = OP_CLEAR;
            end else begin
                op = OP_W'($urandom_range(OP_CLEAR + 1, OP_CODE_MAX));
            end
        end
        offer_cmd(op, pos, h);
    endtask

    // appends until refused, then works at the top end of a full list
    task automatic fill_list();
        while (held < CAPACITY) offer_cmd(OP_APPEND, 0, pick_handle());
        repeat (3) offer_cmd(OP_APPEND, 0, pick_handle());
        offer_cmd(OP_READ, 32767, '0);
        offer_cmd(OP_READ, CAPACITY - 1, '0);
        offer_cmd(OP_REMOVE_AT, CAPACITY, '0);
        offer_cmd(OP_REMOVE_AT, CAPACITY - 1, '0);
        offer_cmd(OP_APPEND, 0, pick_handle());
        offer_cmd(OP_APPEND, 0, pick_handle());
    endtask

    initial begin : stimulus
        int phase;
        int len;
        int pct_choices [3];
        int grow_choices [3];
        pct_choices  = '{0, 15, 40};
        grow_choices = '{20, 45, 70};
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) handle_pool[i] = HANDLE_W'($urandom);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        idle_pct = 15;
        offer_cmd(OP_READ, 0, '0);
        offer_cmd(OP_REMOVE_AT, 0, '0);
        offer_cmd(OP_REMOVE_HANDLE, 0, '0);
        offer_cmd(OP_APPEND, 0, 16'h0000);
        offer_cmd(OP_APPEND, 0, 16'hFFFF);
        offer_cmd(OP_APPEND, 0, 16'h1234);
        offer_cmd(OP_APPEND, 0, 16'hFFFF);
        offer_cmd(OP_READ, -32768, '0);
        offer_cmd(OP_READ, 32767, '0);
        offer_cmd(OP_READ, 1, '0);
        offer_cmd(OP_REMOVE_HANDLE, 0, 16'hFFFF);
        offer_cmd(OP_REMOVE_HANDLE, 0, 16'hBEEF);
        offer_cmd(OP_REMOVE_AT, -1, '0);
        offer_cmd(OP_REMOVE_AT, 3, '0);
        offer_cmd(OP_REMOVE_AT, 32767, '0);
        offer_cmd(OP_REMOVE_AT, 0, '0);
        offer_cmd(OP_READ, 0, '0);
        for (int u = OP_CLEAR + 1; u <= OP_CODE_MAX; u++)
            offer_cmd(OP_W'(u), pick_position(), pick_handle());
        offer_cmd(OP_REMOVE_AT, -32768, '0);
        offer_cmd(OP_CLEAR, 0, '0);
        offer_cmd(OP_READ, 5, '0);
        offer_cmd(OP_APPEND, 0, 16'h5555);
        offer_cmd(OP_APPEND, 0, 16'hAAAA);

        phase = 0;
        while (cmds_queued < CMD_TARGET) begin
            idle_pct = pct_choices[$urandom_range(0, 2)];
            if (phase == 2) hold_requests++;
            if (phase == 1 || phase == 7) begin
                fill_list();
            end else begin
                len = $urandom_range(30, 70);
                for (int k = 0; k < len && cmds_queued < CMD_TARGET; k++)
                    offer_random_cmd(grow_choices[$urandom_range(0, 2)]);
            end
            if (phase == 3) await_drained();
            phase++;
        end

        await_drained();
        repeat (DRAIN_GRACE) @(posedge i_clk);
        if (due_replies.size() != 0) begin
            $error("%0d results never arrived", due_replies.size());
            mismatches++;
        end
        $display("checked %0d operations; list length peaked at %0d of %0d",
                 items_checked, peak_len, CAPACITY);
        $display("%0d appends refused as full, %0d misses, %0d reads",
                 full_refusals, misses, reads_done);
        if (mismatches == 0) begin
            $display("compacting_handle_list: match");
        end else begin
            $display("compacting_handle_list: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/chl_pkg.sv
hdl/chl_ram.sv
hdl/compacting_handle_list.sv
bench/testbench.sv
